// ===== sv/clf_pkg.sv =====
// Shared types, codes and defaults of the concurrency limiter
`default_nettype none
package clf_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF = 8;
	localparam int CMD_W = 2;
	localparam int TAG_W = 8;
	localparam int TICKET_W = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W = 8;
	localparam int LIMIT_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_DONE = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_STARTED = 3'd0,
		STAT_QUEUED = 3'd1,
		STAT_CANCEL_HIT = 3'd2,
		STAT_CANCEL_MISS = 3'd3,
		STAT_DONE_IDLE = 3'd4,
		STAT_FULL = 3'd5,
		STAT_DONE_ERROR = 3'd6
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_POP
	} fsm_t;
endpackage
`default_nettype wire

// ===== sv/clf_if.sv =====
// Channel interfaces: command items, result items, limit register writes
`default_nettype none
interface clf_cmd_if;
	logic valid;
	logic ready;
	logic [clf_pkg::CMD_W-1:0] command;
	logic [clf_pkg::TAG_W-1:0] job_tag;
	logic [clf_pkg::TICKET_W-1:0] cancel_ticket;
	modport source (output valid, command, job_tag, cancel_ticket, input ready);
	modport sink (input valid, command, job_tag, cancel_ticket, output ready);
endinterface

interface clf_res_if;
	logic valid;
	logic ready;
	logic start_valid;
	logic [clf_pkg::TAG_W-1:0] start_tag;
	logic [clf_pkg::TICKET_W-1:0] ticket;
	logic [clf_pkg::STATUS_W-1:0] status;
	logic [clf_pkg::COUNT_W-1:0] running_now;
	modport source (output valid, start_valid, start_tag, ticket, status, running_now,
		input ready);
	modport sink (input valid, start_valid, start_tag, ticket, status, running_now,
		output ready);
endinterface

interface clf_cfg_if;
	logic valid;
	logic ready;
	logic [clf_pkg::LIMIT_W-1:0] concurrency_limit;
	modport source (output valid, concurrency_limit, input ready);
	modport sink (input valid, concurrency_limit, output ready);
endinterface
`default_nettype wire

// ===== sv/concurrency_limiter_fifo.sv =====
// Concurrency limiter top level: admission control, wait queue and result register
//
// Admits jobs up to concurrency_limit at once and queues the rest, in order, while
// there is room, in a QUEUE_DEPTH-entry FIFO held in two RAMs (tags and dead marks).
// Items are answered from the idle state, except a done item while jobs run and
// wait: it pops 1 to QUEUE_DEPTH queue entries until one is live or none is left.
// The pop loop reads one entry per cycle through the single read port of the queue
// RAMs; the final pop waits for a free result register. One item is handled at a
// time; a new item is taken no earlier than the cycle in which the previous result
// item is taken, so a waiting result holds off the next item.
// The queue RAMs need no clearing after reset. The limit register resets to 1.
`default_nettype none
module concurrency_limiter_fifo #(
	parameter int QUEUE_DEPTH = clf_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS = clf_pkg::TAG_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	clf_cmd_if.sink cmd,
	clf_res_if.source res,
	clf_cfg_if.sink cfg
);
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int KEEP_BITS = (TAG_BITS < clf_pkg::TAG_W) ? TAG_BITS : clf_pkg::TAG_W;
	localparam logic [SW:0] DEPTH_W = (SW+1)'(QUEUE_DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);

	clf_pkg::fsm_t state_q, state_d;
	logic [clf_pkg::COUNT_W-1:0] running_q, running_d;
	logic [clf_pkg::LIMIT_W-1:0] limit_q;
	logic [SW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [clf_pkg::TICKET_W-1:0] seq_q, seq_d;

	logic out_valid_q, out_valid_d;
	logic start_valid_q, start_valid_d;
	logic [clf_pkg::TAG_W-1:0] start_tag_q, start_tag_d;
	logic [clf_pkg::TICKET_W-1:0] ticket_q, ticket_d;
	clf_pkg::status_t status_q, status_d;
	logic load;

	logic out_free, accept;
	logic [TAG_BITS-1:0] tag_in, tag_rd;
	logic [clf_pkg::TAG_W-1:0] tag_in_w, tag_rd_w;
	logic dead_rd;
	logic [SW:0] tail_sum, cancel_sum;
	logic [SW-1:0] tail_slot, cancel_slot, head_inc;
	logic [clf_pkg::TICKET_W-1:0] cancel_off;
	logic cancel_hit;

	logic tag_we, dead_we, dead_wdata;
	logic [SW-1:0] dead_waddr;
	logic live, last_entry, final_pop;

	assign out_free = !out_valid_q || res.ready;
	assign cmd.ready = (state_q == clf_pkg::FSM_IDLE) && out_free;
	assign accept = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		tag_in = '0;
		tag_in_w = '0;
		tag_rd_w = '0;
		for (int i = 0; i < KEEP_BITS; i++) begin
			tag_in[i] = cmd.job_tag[i];
			tag_in_w[i] = cmd.job_tag[i];
			tag_rd_w[i] = tag_rd[i];
		end
	end

	assign tail_sum = {1'b0, head_q} + (SW+1)'(count_q);
	assign tail_slot = (tail_sum >= DEPTH_W) ? SW'(tail_sum - DEPTH_W) : tail_sum[SW-1:0];
	assign cancel_off = cmd.cancel_ticket - seq_q;
	assign cancel_hit = cancel_off < clf_pkg::TICKET_W'(count_q);
	assign cancel_sum = {1'b0, head_q} + cancel_off[SW:0];
	assign cancel_slot = (cancel_sum >= DEPTH_W) ? SW'(cancel_sum - DEPTH_W)
		: cancel_sum[SW-1:0];
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + SW'(1);

	assign live = !dead_rd;
	assign last_entry = (count_q == CW'(1));
	assign final_pop = live || last_entry;

	always_comb begin
		state_d = state_q;
		running_d = running_q;
		head_d = head_q;
		count_d = count_q;
		seq_d = seq_q;
		load = 1'b0;
		start_valid_d = 1'b0;
		start_tag_d = '0;
		ticket_d = '0;
		status_d = clf_pkg::STAT_CANCEL_MISS;
		tag_we = 1'b0;
		dead_we = 1'b0;
		dead_waddr = tail_slot;
		dead_wdata = 1'b0;
		case (state_q)
			clf_pkg::FSM_IDLE: begin
				if (accept) begin
					case (cmd.command)
						clf_pkg::CMD_SCHEDULE: begin
							load = 1'b1;
							if (running_q < limit_q) begin
								running_d = running_q + 1'b1;
								start_valid_d = 1'b1;
								start_tag_d = tag_in_w;
								status_d = clf_pkg::STAT_STARTED;
							end else if (count_q >= CW'(QUEUE_DEPTH)) begin
								status_d = clf_pkg::STAT_FULL;
							end else begin
								tag_we = 1'b1;
								dead_we = 1'b1;
								ticket_d = seq_q + clf_pkg::TICKET_W'(count_q);
								count_d = count_q + CW'(1);
								status_d = clf_pkg::STAT_QUEUED;
							end
						end
						clf_pkg::CMD_CANCEL: begin
							load = 1'b1;
							if (cancel_hit) begin
								dead_we = 1'b1;
								dead_waddr = cancel_slot;
								dead_wdata = 1'b1;
								status_d = clf_pkg::STAT_CANCEL_HIT;
							end
						end
						clf_pkg::CMD_DONE: begin
							if (running_q == '0) begin
								load = 1'b1;
								status_d = clf_pkg::STAT_DONE_ERROR;
							end else begin
								running_d = running_q - 1'b1;
								if (count_q == '0) begin
									load = 1'b1;
									status_d = clf_pkg::STAT_DONE_IDLE;
								end else begin
									state_d = clf_pkg::FSM_POP;
								end
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			clf_pkg::FSM_POP: begin
				if (!final_pop || out_free) begin
					head_d = head_inc;
					seq_d = seq_q + 1'b1;
					count_d = count_q - CW'(1);
					if (final_pop) begin
						load = 1'b1;
						state_d = clf_pkg::FSM_IDLE;
						if (live) begin
							running_d = running_q + 1'b1;
							start_valid_d = 1'b1;
							start_tag_d = tag_rd_w;
							status_d = clf_pkg::STAT_STARTED;
						end else begin
							status_d = clf_pkg::STAT_DONE_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = clf_pkg::FSM_IDLE;
			end
		endcase
		out_valid_d = load ? 1'b1 : (out_valid_q && !res.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clf_pkg::FSM_IDLE;
			running_q <= '0;
			limit_q <= clf_pkg::LIMIT_W'(1);
			head_q <= '0;
			count_q <= '0;
			seq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			running_q <= running_d;
			head_q <= head_d;
			count_q <= count_d;
			seq_q <= seq_d;
			out_valid_q <= out_valid_d;
			if (cfg.valid) begin
				limit_q <= cfg.concurrency_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_valid_q <= start_valid_d;
			start_tag_q <= start_tag_d;
			ticket_q <= ticket_d;
			status_q <= status_d;
		end
	end

	clf_ram #(
		.WIDTH(TAG_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_tag_ram (
		.clk(clk),
		.wr_en(tag_we),
		.wr_addr(tail_slot),
		.wr_data(tag_in),
		.rd_addr(head_d),
		.rd_data(tag_rd)
	);

	clf_ram #(
		.WIDTH(1),
		.DEPTH(QUEUE_DEPTH)
	) u_dead_ram (
		.clk(clk),
		.wr_en(dead_we),
		.wr_addr(dead_waddr),
		.wr_data(dead_wdata),
		.rd_addr(head_d),
		.rd_data(dead_rd)
	);

	assign res.valid = out_valid_q;
	assign res.start_valid = start_valid_q;
	assign res.start_tag = start_tag_q;
	assign res.ticket = ticket_q;
	assign res.status = status_q;
	assign res.running_now = running_q;
endmodule
`default_nettype wire

// ===== sv/clf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module clf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire
